### design/stv_pkg.sv
`timescale 1ns / 1ps

package stv_pkg;

    localparam int KNOB_MAX    = 4;
    localparam int ANGLE_W     = 12;
    localparam int CELSIUS_W   = 9;
    localparam int TIMER_W     = 16;
    localparam int TEMP_W      = 13;
    localparam int CONF_W      = 7;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_CLOSE     = 2'd1,
        OP_ALARM_ON  = 2'd2,
        OP_ALARM_OFF = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PAN_SAFE     = 2'd0,
        PAN_OVERHEAT = 2'd1,
        PAN_SMOKING  = 2'd2,
        PAN_FLAMING  = 2'd3
    } pan_class_t;

    localparam logic ALERT_SMOLDER = 1'b0;
    localparam logic ALERT_FLAME   = 1'b1;

    localparam logic [CONF_W-1:0] CONF_TIMER = 7'd80;
    localparam logic [CONF_W-1:0] CONF_SMOKE = 7'd85;
    localparam logic [CONF_W-1:0] CONF_FLAME = 7'd95;

    // x/10 for x < 4096 as (x * 3277) >> 15
    localparam logic [ANGLE_W-1:0] DIV10_MUL   = 12'd3277;
    localparam int                 DIV10_SHIFT = 15;
    // tenths at or below this truncate to a negative whole degree
    localparam logic signed [TEMP_W-1:0] TEMP_NEG_LIMIT = -13'sd10;

    localparam logic [CFG_INDEX_W-1:0] CFG_KNOB_ON   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_TWO = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_THR = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OVERHEAT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SMOKING   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_IGNITE    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNATTEND  = 3'd6;

    typedef logic [KNOB_MAX-1:0][ANGLE_W-1:0] knob_angles_t;

    // one classified item handed to the control stage
    typedef struct packed {
        op_t                         op;
        logic [KNOB_MAX-1:0]         on_mask;
        logic [2*KNOB_MAX-1:0]       levels;
        pan_class_t                  pan_class;
    } item_t;

endpackage

### design/stv_knob_class.sv
`timescale 1ns / 1ps

module stv_knob_class #(
    parameter int KNOB_COUNT = 4
) (
    input  stv_pkg::knob_angles_t             angles,
    input  logic [stv_pkg::ANGLE_W-1:0]       on_threshold,
    input  logic [stv_pkg::ANGLE_W-1:0]       two_threshold,
    input  logic [stv_pkg::ANGLE_W-1:0]       three_threshold,
    output logic [stv_pkg::KNOB_MAX-1:0]      on_mask,
    output logic [2*stv_pkg::KNOB_MAX-1:0]    levels
);
    import stv_pkg::*;

    always_comb begin
        on_mask = '0;
        levels  = '0;
        for (int i = 0; i < KNOB_MAX; i++) begin
            if ((i < KNOB_COUNT) && (angles[i] > on_threshold)) begin
                on_mask[i] = 1'b1;
                if (angles[i] > three_threshold) begin
                    levels[2*i +: 2] = 2'd3;
                end else if (angles[i] > two_threshold) begin
                    levels[2*i +: 2] = 2'd2;
                end else begin
                    levels[2*i +: 2] = 2'd1;
                end
            end
        end
    end

endmodule

### design/stv_pan_class.sv
`timescale 1ns / 1ps

module stv_pan_class (
    input  logic signed [stv_pkg::TEMP_W-1:0]   temp_tenths,
    input  logic [stv_pkg::CELSIUS_W-1:0]       overheat_c,
    input  logic [stv_pkg::CELSIUS_W-1:0]       smoking_c,
    input  logic [stv_pkg::CELSIUS_W-1:0]       ignite_c,
    output stv_pkg::pan_class_t                 pan_class
);
    import stv_pkg::*;

    logic [ANGLE_W-1:0]   mag;
    logic [2*ANGLE_W-1:0] prod;
    logic [CELSIUS_W-1:0] deg;
    logic                 below_zero;

    // small negatives truncate to zero degrees, the rest are below every threshold
    assign below_zero = (temp_tenths <= TEMP_NEG_LIMIT);
    assign mag  = temp_tenths[TEMP_W-1] ? '0 : temp_tenths[ANGLE_W-1:0];
    assign prod = mag * DIV10_MUL;
    assign deg  = prod[DIV10_SHIFT +: CELSIUS_W];

    always_comb begin
        priority if (below_zero) begin
            pan_class = PAN_SAFE;
        end else if (deg >= ignite_c) begin
            pan_class = PAN_FLAMING;
        end else if (deg >= smoking_c) begin
            pan_class = PAN_SMOKING;
        end else if (deg > overheat_c) begin
            pan_class = PAN_OVERHEAT;
        end else begin
            pan_class = PAN_SAFE;
        end
    end

endmodule

### design/stv_ctrl.sv
`timescale 1ns / 1ps

module stv_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    input  stv_pkg::item_t                item,
    input  logic [stv_pkg::TIMER_W-1:0]   unattended_seconds,
    output logic                          item_take,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,  // on_mask, levels, pan_class, timer_left,
                                                    // valve_is_closed, buzzer_on, alert_confidence
    output logic [1:0]                    m_tuser,  // alert_valid, alert_kind
    output logic                          m_tlast
);
    import stv_pkg::*;

    logic [TIMER_W-1:0]    timer_reg, timer_next;
    logic                  valve_reg, valve_next;
    logic                  buzzer_reg, buzzer_next;
    logic [KNOB_MAX-1:0]   mask_reg;
    logic [2*KNOB_MAX-1:0] levels_reg;
    pan_class_t            class_reg;

    logic                  out_valid_reg;
    logic [1:0]            count_reg, count_next;
    logic                  idx_reg;
    logic                  kind0_reg, kind0_next, kind1_reg, kind1_next;
    logic [CONF_W-1:0]     conf0_reg, conf0_next, conf1_reg, conf1_next;

    logic is_tick, burning, expire, flame, smoke, class_alert;
    logic cur_last, out_fire;
    logic cur_kind;
    logic [CONF_W-1:0] cur_conf;

    assign is_tick     = (item.op == OP_TICK);
    assign burning     = is_tick && (item.on_mask != '0);
    assign expire      = burning && (timer_reg == TIMER_W'(1));
    assign flame       = is_tick && (item.pan_class == PAN_FLAMING);
    assign smoke       = is_tick && (item.pan_class == PAN_SMOKING);
    assign class_alert = flame || smoke;

    assign cur_last  = (count_reg != 2'd2) || idx_reg;
    assign out_fire  = out_valid_reg && m_tready;
    assign item_take = item_valid && (!out_valid_reg || (out_fire && cur_last));

    always_comb begin
        timer_next = timer_reg;
        if (burning) begin
            timer_next = (timer_reg == '0) ? unattended_seconds : timer_reg - TIMER_W'(1);
        end
        valve_next  = valve_reg || expire || class_alert;
        buzzer_next = buzzer_reg || expire || class_alert;
        unique case (item.op)
            OP_TICK:      ;
            OP_CLOSE:     valve_next  = 1'b1;
            OP_ALARM_ON:  buzzer_next = 1'b1;
            OP_ALARM_OFF: buzzer_next = 1'b0;
            default:      ;
        endcase
        count_next = {1'b0, expire} + {1'b0, class_alert};
        kind1_next = flame ? ALERT_FLAME : ALERT_SMOLDER;
        conf1_next = flame ? CONF_FLAME : CONF_SMOKE;
        // timer expiry goes out ahead of the pan alert
        kind0_next = expire ? ALERT_SMOLDER : kind1_next;
        conf0_next = expire ? CONF_TIMER : conf1_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg     <= '0;
            valve_reg     <= 1'b0;
            buzzer_reg    <= 1'b0;
            mask_reg      <= '0;
            levels_reg    <= '0;
            class_reg     <= PAN_SAFE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= 1'b0;
        end else begin
            if (item_take) begin
                timer_reg     <= timer_next;
                valve_reg     <= valve_next;
                buzzer_reg    <= buzzer_next;
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
                idx_reg       <= 1'b0;
                if (is_tick) begin
                    mask_reg   <= item.on_mask;
                    levels_reg <= item.levels;
                    class_reg  <= item.pan_class;
                end
            end else if (out_fire) begin
                if (cur_last) begin
                    out_valid_reg <= 1'b0;
                end else begin
                    idx_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take) begin
            kind0_reg <= kind0_next;
            conf0_reg <= conf0_next;
            kind1_reg <= kind1_next;
            conf1_reg <= conf1_next;
        end
    end

    assign cur_kind = (count_reg == '0) ? 1'b0 : (idx_reg ? kind1_reg : kind0_reg);
    assign cur_conf = (count_reg == '0) ? '0 : (idx_reg ? conf1_reg : conf0_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = cur_last;
    assign m_tuser  = {cur_kind, (count_reg != '0)};
    assign m_tdata  = {1'b0, cur_conf, buzzer_reg, valve_reg, timer_reg,
                       class_reg, levels_reg, mask_reg};

`ifndef ASSERT_OFF
    a_alert_shuts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (valve_reg && buzzer_reg))
        else $error("alert without valve closed and buzzer on");

    a_pair_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (count_reg == 2'd2) && !idx_reg) |-> !m_tlast)
        else $error("first of two alerts marked last");

    a_expiry_timer_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] && (m_tdata[38:32] == CONF_TIMER)) |-> (timer_reg == '0))
        else $error("timer alert with timer still running");

    a_second_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && idx_reg))
        else $error("second alert lost");
`endif

endmodule

### design/stove_safety_interlock.sv
`timescale 1ns / 1ps
// m_tvalid rises once an accepted item has passed the input register, then the result register
// throughput: one item per cycle while m_tready is high; a two-alert item takes two result beats
// the input register feeds the classifiers and timer update, the result register holds alerts
// reset: synchronous active-low aresetn clears timer, valve, buzzer, held status and
// restores the default thresholds; no clearing pass is needed

module stove_safety_interlock #(
    parameter int KNOB_COUNT = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [63:0]                         s_tdata,  // knob_a_angle, knob_b_angle,
                                                          // knob_c_angle, knob_d_angle,
                                                          // peak_temp_tenths
    input  logic [1:0]                          s_tuser,  // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [39:0]                         m_tdata,  // burner_on_mask, burner_levels,
                                                          // pan_class, timer_left,
                                                          // valve_is_closed, buzzer_on,
                                                          // alert_confidence
    output logic [1:0]                          m_tuser,  // alert_valid, alert_kind
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [stv_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [stv_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import stv_pkg::*;

    logic [ANGLE_W-1:0]   knob_on_reg, level_two_reg, level_three_reg;
    logic [CELSIUS_W-1:0] overheat_reg, smoking_reg, ignite_reg;
    logic [TIMER_W-1:0]   unattended_reg;

    logic                      in_valid_reg;
    op_t                       op_reg;
    knob_angles_t              angles_reg;
    logic signed [TEMP_W-1:0]  temp_reg;

    logic                      item_take;
    logic                      s_fire;
    item_t                     item;
    logic [KNOB_MAX-1:0]       on_mask;
    logic [2*KNOB_MAX-1:0]     levels;
    pan_class_t                pan_class;

    assign cfg_ready = 1'b1;
    assign s_tready  = !in_valid_reg || item_take;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            knob_on_reg     <= 12'd50;
            level_two_reg   <= 12'd400;
            level_three_reg <= 12'd700;
            overheat_reg    <= 9'd200;
            smoking_reg     <= 9'd232;
            ignite_reg      <= 9'd315;
            unattended_reg  <= 16'd1800;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_KNOB_ON:   knob_on_reg     <= cfg_data[ANGLE_W-1:0];
                CFG_LEVEL_TWO: level_two_reg   <= cfg_data[ANGLE_W-1:0];
                CFG_LEVEL_THR: level_three_reg <= cfg_data[ANGLE_W-1:0];
                CFG_OVERHEAT:  overheat_reg    <= cfg_data[CELSIUS_W-1:0];
                CFG_SMOKING:   smoking_reg     <= cfg_data[CELSIUS_W-1:0];
                CFG_IGNITE:    ignite_reg      <= cfg_data[CELSIUS_W-1:0];
                CFG_UNATTEND:  unattended_reg  <= cfg_data[TIMER_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (item_take) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg     <= op_t'(s_tuser);
            angles_reg <= {s_tdata[47:36], s_tdata[35:24], s_tdata[23:12], s_tdata[11:0]};
            temp_reg   <= s_tdata[60:48];
        end
    end

    stv_knob_class #(
        .KNOB_COUNT (KNOB_COUNT)
    ) u_knob (
        .angles          (angles_reg),
        .on_threshold    (knob_on_reg),
        .two_threshold   (level_two_reg),
        .three_threshold (level_three_reg),
        .on_mask         (on_mask),
        .levels          (levels)
    );

    stv_pan_class u_pan (
        .temp_tenths (temp_reg),
        .overheat_c  (overheat_reg),
        .smoking_c   (smoking_reg),
        .ignite_c    (ignite_reg),
        .pan_class   (pan_class)
    );

    assign item.op        = op_reg;
    assign item.on_mask   = on_mask;
    assign item.levels    = levels;
    assign item.pan_class = pan_class;

    stv_ctrl u_ctrl (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .item_valid         (in_valid_reg),
        .item               (item),
        .unattended_seconds (unattended_reg),
        .item_take          (item_take),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tuser            (m_tuser),
        .m_tlast            (m_tlast)
    );

endmodule
